// ===== rtl/grid_chunk_address_calc_core_macros.svh =====
// assertion macros for the grid chunk address calculator
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GRID_CHUNK_ADDRESS_CALC_CORE_MACROS_SVH
`define GRID_CHUNK_ADDRESS_CALC_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define GCAC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gcac check failed");

// consequence must hold in the cycle after the antecedent
`define GCAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcac sequence check failed");

`endif

// ===== rtl/gcac_pkg.sv =====
// shared constants, types and helpers of the grid chunk address calculator
// no dependencies
package gcac_pkg;

    localparam int AXES           = 4;
    localparam int CFG_W          = 13;
    localparam int ID_W           = 48;
    localparam int INDEX_BITS_DEF = 12;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    // axis order: time slowest, longitude fastest
    localparam int AX_TIME  = 0;
    localparam int AX_DEPTH = 1;
    localparam int AX_LAT   = 2;
    localparam int AX_LON   = 3;

    // register indexes
    localparam logic [2:0] REG_TIME_EXTENT  = 3'd0;
    localparam logic [2:0] REG_DEPTH_EXTENT = 3'd1;
    localparam logic [2:0] REG_LAT_EXTENT   = 3'd2;
    localparam logic [2:0] REG_LON_EXTENT   = 3'd3;
    localparam logic [2:0] REG_TIME_CHUNK   = 3'd4;
    localparam logic [2:0] REG_DEPTH_CHUNK  = 3'd5;
    localparam logic [2:0] REG_LAT_CHUNK    = 3'd6;
    localparam logic [2:0] REG_LON_CHUNK    = 3'd7;

    typedef logic [CFG_W-1:0] t_cfg_word;

    // configuration as seen by the datapath
    typedef struct packed {
        logic                       busy;  // chunk counts being recomputed
        logic [AXES-1:0][CFG_W-1:0] ext;   // axis extents
        logic [AXES-1:0][CFG_W-1:0] size;  // chunk sizes, zero taken as one
        logic [AXES-1:0][CFG_W-1:0] cpa;   // chunks per axis
    } t_cfg;

    // a chunk size of zero behaves as one
    function automatic t_cfg_word eff_size(input t_cfg_word s);
        return (s == '0) ? t_cfg_word'(1) : s;
    endfunction

endpackage

// ===== rtl/gcac_ifs.sv =====
// valid/ready channel interfaces for index beats and result beats
// depends on gcac_pkg
interface gcac_in_if #(parameter int IW = gcac_pkg::INDEX_BITS_DEF);
    logic          valid;
    logic          ready;
    logic [IW-1:0] time_idx;
    logic [IW-1:0] depth_idx;
    logic [IW-1:0] lat_idx;
    logic [IW-1:0] lon_idx;

    modport source (output valid, time_idx, depth_idx, lat_idx, lon_idx, input ready);
    modport sink   (input valid, time_idx, depth_idx, lat_idx, lon_idx, output ready);
endinterface

interface gcac_out_if #(parameter int IW = gcac_pkg::INDEX_BITS_DEF);
    logic                        valid;
    logic                        ready;
    logic                        in_range;
    logic [gcac_pkg::ID_W-1:0]   chunk_id;
    logic [IW-1:0]               time_start;
    logic [IW-1:0]               depth_start;
    logic [IW-1:0]               lat_start;
    logic [IW-1:0]               lon_start;
    logic [gcac_pkg::CFG_W-1:0]  time_len;
    logic [gcac_pkg::CFG_W-1:0]  depth_len;
    logic [gcac_pkg::CFG_W-1:0]  lat_len;
    logic [gcac_pkg::CFG_W-1:0]  lon_len;

    modport source (output valid, in_range, chunk_id, time_start, depth_start, lat_start,
                    lon_start, time_len, depth_len, lat_len, lon_len, input ready);
    modport sink   (input valid, in_range, chunk_id, time_start, depth_start, lat_start,
                    lon_start, time_len, depth_len, lat_len, lon_len, output ready);
endinterface

// ===== rtl/grid_chunk_address_calc_core.sv =====
// Grid chunk address calculator: takes a four-axis grid index (time, depth, latitude,
// longitude) and returns its in-range flag, linear chunk id (longitude fastest), chunk
// start and clipped chunk length per axis. One index beat is taken every cycle unless the
// result side stalls or chunk counts are being recomputed; each result passes through
// INDEX_BITS divider stages, one quotient bit each, then three stages of start/length and
// the chunk id multiplies; a stall on the result side backs up through the pipeline
// without losing beats. After any register write a single serial divider recomputes
// chunks per axis, for the four axes in turn, during which no index beat is accepted.
// Registers sit on an APB port at byte address 4*i, reads return the low CFG_W bits of the written value.
// depends on gcac_pkg, gcac_ifs, gcac_cfg, gcac_div_pipe, gcac_post and the macros header
`include "grid_chunk_address_calc_core_macros.svh"

module grid_chunk_address_calc_core #(
    parameter int INDEX_BITS = gcac_pkg::INDEX_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcac_pkg::APB_AW-1:0] paddr,
    input  logic [gcac_pkg::APB_DW-1:0] pwdata,
    output logic [gcac_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // index beats in, result beats out
    gcac_in_if.sink                     i_in,
    gcac_out_if.source                  o_out
);
    import gcac_pkg::*;

    t_cfg                            w_cfg;
    logic [AXES-1:0][INDEX_BITS-1:0] w_idx;
    logic                            w_div_valid;
    logic                            w_div_ready;
    logic                            w_mid_valid;
    logic                            w_mid_ready;
    logic [AXES-1:0][INDEX_BITS-1:0] w_mid_idx;
    logic [AXES-1:0][INDEX_BITS-1:0] w_mid_quo;
    logic [AXES-1:0][CFG_W-1:0]      w_mid_rem;
    logic [AXES-1:0][INDEX_BITS-1:0] w_start;
    logic [AXES-1:0][CFG_W-1:0]      w_len;
    logic                            w_lens_ok;

    // registers and chunk count recompute
    gcac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // hold off index beats while chunk counts are stale
    assign w_div_valid     = i_in.valid && !w_cfg.busy;
    assign i_in.ready      = w_div_ready && !w_cfg.busy;
    assign w_idx[AX_TIME]  = i_in.time_idx;
    assign w_idx[AX_DEPTH] = i_in.depth_idx;
    assign w_idx[AX_LAT]   = i_in.lat_idx;
    assign w_idx[AX_LON]   = i_in.lon_idx;

    // chunk index and remainder per axis
    gcac_div_pipe #(.IW(INDEX_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_idx   (w_idx),
        .i_cfg   (w_cfg),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_idx   (w_mid_idx),
        .o_quo   (w_mid_quo),
        .o_rem   (w_mid_rem)
    );

    // starts, lengths and chunk id; last stage is the output register
    gcac_post #(.IW(INDEX_BITS)) u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_mid_valid),
        .o_ready    (w_mid_ready),
        .i_idx      (w_mid_idx),
        .i_quo      (w_mid_quo),
        .i_rem      (w_mid_rem),
        .i_cfg      (w_cfg),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_in_range (o_out.in_range),
        .o_chunk_id (o_out.chunk_id),
        .o_start    (w_start),
        .o_len      (w_len)
    );

    assign o_out.time_start  = w_start[AX_TIME];
    assign o_out.depth_start = w_start[AX_DEPTH];
    assign o_out.lat_start   = w_start[AX_LAT];
    assign o_out.lon_start   = w_start[AX_LON];
    assign o_out.time_len    = w_len[AX_TIME];
    assign o_out.depth_len   = w_len[AX_DEPTH];
    assign o_out.lat_len     = w_len[AX_LAT];
    assign o_out.lon_len     = w_len[AX_LON];

    assign w_lens_ok = (o_out.time_len != '0) && (o_out.depth_len != '0)
                    && (o_out.lat_len != '0) && (o_out.lon_len != '0);

    // a register write always kicks off a recompute
    `GCAC_ASSERT_NEXT(a_write_starts_recalc, psel && penable && pwrite, w_cfg.busy)
    // no index beat slips in while chunk counts are stale
    `GCAC_ASSERT(a_no_accept_when_busy, !(w_cfg.busy && i_in.valid && i_in.ready))
    // every delivered length is at least one
    `GCAC_ASSERT(a_len_nonzero, !o_out.valid || w_lens_ok)

endmodule

// ===== rtl/gcac_cfg.sv =====
// apb register file and serial divider that recomputes chunks per axis
// depends on gcac_pkg
module gcac_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcac_pkg::APB_AW-1:0] paddr,
    input  logic [gcac_pkg::APB_DW-1:0] pwdata,
    output logic [gcac_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output gcac_pkg::t_cfg              o_cfg
);
    import gcac_pkg::*;

    localparam int STEP_W = $clog2(CFG_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CFG_W);

    logic [AXES-1:0][CFG_W-1:0] r_ext;
    logic [AXES-1:0][CFG_W-1:0] r_size;
    logic [AXES-1:0][CFG_W-1:0] r_cpa;
    logic                       r_busy;
    logic [1:0]                 r_axis;
    logic [STEP_W-1:0]          r_step;
    logic [CFG_W-1:0]           r_dvd;
    logic [CFG_W-1:0]           r_rem;
    logic [CFG_W-1:0]           r_quo;

    logic             w_wr;
    logic [2:0]       w_idx;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W:0]   w_trial;
    logic [CFG_W:0]   w_div;
    logic             w_ge;
    logic [CFG_W-1:0] n_rem;
    logic [CFG_W-1:0] n_quo;
    logic [CFG_W-1:0] n_cpa;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign w_val  = pwdata[CFG_W-1:0];

    // one quotient bit per cycle
    assign w_div   = {1'b0, eff_size(r_size[r_axis])};
    assign w_trial = {r_rem, r_dvd[CFG_W-1]};
    assign w_ge    = (w_trial >= w_div);
    assign n_rem   = w_ge ? CFG_W'(w_trial - w_div) : w_trial[CFG_W-1:0];
    assign n_quo   = {r_quo[CFG_W-2:0], w_ge};
    // round up when a remainder is left
    assign n_cpa   = CFG_W'(n_quo + CFG_W'(n_rem != '0));

    always_comb begin
        unique case (w_idx)
            REG_TIME_EXTENT:  prdata = APB_DW'(r_ext[AX_TIME]);
            REG_DEPTH_EXTENT: prdata = APB_DW'(r_ext[AX_DEPTH]);
            REG_LAT_EXTENT:   prdata = APB_DW'(r_ext[AX_LAT]);
            REG_LON_EXTENT:   prdata = APB_DW'(r_ext[AX_LON]);
            REG_TIME_CHUNK:   prdata = APB_DW'(r_size[AX_TIME]);
            REG_DEPTH_CHUNK:  prdata = APB_DW'(r_size[AX_DEPTH]);
            REG_LAT_CHUNK:    prdata = APB_DW'(r_size[AX_LAT]);
            REG_LON_CHUNK:    prdata = APB_DW'(r_size[AX_LON]);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_ext[a]  <= CFG_W'(1);
                r_size[a] <= CFG_W'(1);
                r_cpa[a]  <= CFG_W'(1);
            end
            r_busy <= 1'b0;
            r_axis <= '0;
            r_step <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TIME_EXTENT:  r_ext[AX_TIME]   <= w_val;
                REG_DEPTH_EXTENT: r_ext[AX_DEPTH]  <= w_val;
                REG_LAT_EXTENT:   r_ext[AX_LAT]    <= w_val;
                REG_LON_EXTENT:   r_ext[AX_LON]    <= w_val;
                REG_TIME_CHUNK:   r_size[AX_TIME]  <= w_val;
                REG_DEPTH_CHUNK:  r_size[AX_DEPTH] <= w_val;
                REG_LAT_CHUNK:    r_size[AX_LAT]   <= w_val;
                REG_LON_CHUNK:    r_size[AX_LON]   <= w_val;
            endcase
            r_busy <= 1'b1;
            r_axis <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_dvd  <= r_ext[r_axis];
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= STEP_W'(1);
            end else begin
                r_dvd <= {r_dvd[CFG_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_step == STEP_LAST) begin
                    r_cpa[r_axis] <= n_cpa;
                    r_step        <= '0;
                    if (r_axis == 2'(AXES - 1)) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_cfg.busy = r_busy;
        o_cfg.ext  = r_ext;
        o_cfg.cpa  = r_cpa;
        for (int a = 0; a < AXES; a++) begin
            o_cfg.size[a] = eff_size(r_size[a]);
        end
    end

endmodule

// ===== rtl/gcac_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, four axes side by side
// depends on gcac_pkg
module gcac_div_pipe #(
    parameter int IW = gcac_pkg::INDEX_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [gcac_pkg::AXES-1:0][IW-1:0]         i_idx,
    input  gcac_pkg::t_cfg                            i_cfg,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [gcac_pkg::AXES-1:0][IW-1:0]         o_idx,
    output logic [gcac_pkg::AXES-1:0][IW-1:0]         o_quo,
    output logic [gcac_pkg::AXES-1:0][gcac_pkg::CFG_W-1:0] o_rem
);
    import gcac_pkg::*;

    logic                       r_v [IW];
    logic [AXES-1:0][IW-1:0]    r_x [IW];
    logic [AXES-1:0][IW-1:0]    r_q [IW];
    logic [AXES-1:0][CFG_W-1:0] r_r [IW];
    logic [IW-1:0]              w_en;

    for (genvar g = 0; g < IW; g++) begin : g_stage
        logic                       v_in;
        logic [AXES-1:0][IW-1:0]    x_in;
        logic [AXES-1:0][IW-1:0]    q_in;
        logic [AXES-1:0][CFG_W-1:0] r_in;
        logic [AXES-1:0][CFG_W:0]   t;
        logic [AXES-1:0][CFG_W:0]   d;
        logic [AXES-1:0]            ge;
        logic [AXES-1:0][IW-1:0]    n_q;
        logic [AXES-1:0][CFG_W-1:0] n_r;

        if (g == 0) begin : g_head
            assign v_in = i_valid;
            assign x_in = i_idx;
            assign q_in = '0;
            assign r_in = '0;
        end else begin : g_body
            assign v_in = r_v[g-1];
            assign x_in = r_x[g-1];
            assign q_in = r_q[g-1];
            assign r_in = r_r[g-1];
        end

        if (g == IW - 1) begin : g_tail_en
            assign w_en[g] = !r_v[g] || i_ready;
        end else begin : g_mid_en
            assign w_en[g] = !r_v[g] || w_en[g+1];
        end

        always_comb begin
            for (int a = 0; a < AXES; a++) begin
                t[a]  = {r_in[a], x_in[a][IW-1-g]};
                d[a]  = {1'b0, i_cfg.size[a]};
                ge[a] = (t[a] >= d[a]);
                n_r[a] = ge[a] ? CFG_W'(t[a] - d[a]) : t[a][CFG_W-1:0];
                n_q[a] = q_in[a];
                n_q[a][IW-1-g] = ge[a];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_en[g]) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[g] && v_in) begin
                r_x[g] <= x_in;
                r_q[g] <= n_q;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[IW-1];
    assign o_idx   = r_x[IW-1];
    assign o_quo   = r_q[IW-1];
    assign o_rem   = r_r[IW-1];

endmodule

// ===== rtl/gcac_post.sv =====
// chunk starts, clipped lengths, range flag and horner chunk id over three stages
// depends on gcac_pkg
module gcac_post #(
    parameter int IW = gcac_pkg::INDEX_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [gcac_pkg::AXES-1:0][IW-1:0]              i_idx,
    input  logic [gcac_pkg::AXES-1:0][IW-1:0]              i_quo,
    input  logic [gcac_pkg::AXES-1:0][gcac_pkg::CFG_W-1:0] i_rem,
    input  gcac_pkg::t_cfg                                 i_cfg,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic                                           o_in_range,
    output logic [gcac_pkg::ID_W-1:0]                      o_chunk_id,
    output logic [gcac_pkg::AXES-1:0][IW-1:0]              o_start,
    output logic [gcac_pkg::AXES-1:0][gcac_pkg::CFG_W-1:0] o_len
);
    import gcac_pkg::*;

    localparam int MW  = ((IW > CFG_W) ? IW : CFG_W) + 1;
    localparam int P1W = IW + CFG_W;
    localparam int P2W = IW + 2 * CFG_W;

    logic                       r_v1, r_v2, r_v3;
    logic                       w_en1, w_en2, w_en3;
    logic [AXES-1:0][IW-1:0]    r_start1, r_start2, r_start3;
    logic [AXES-1:0][CFG_W-1:0] r_len1, r_len2, r_len3;
    logic                       r_in1, r_in2, r_in3;
    logic [P1W-1:0]             r_p1;
    logic [P2W-1:0]             r_p2;
    logic [ID_W-1:0]            r_id;
    logic [IW-1:0]              r_qlat1, r_qlon1, r_qlon2;

    logic [AXES-1:0][IW-1:0]    n_start;
    logic [AXES-1:0][CFG_W-1:0] n_len;
    logic [AXES-1:0][MW-1:0]    w_diff;
    logic [AXES-1:0]            w_ok;
    logic [P1W-1:0]             n_p1;
    logic [P2W-1:0]             n_p2;
    logic [ID_W-1:0]            n_id;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // start is the index less its remainder, length clipped at the extent
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_start[a] = i_idx[a] - IW'(i_rem[a]);
            w_ok[a]    = (MW'(i_idx[a]) < MW'(i_cfg.ext[a]));
            w_diff[a]  = MW'(i_cfg.ext[a]) - MW'(n_start[a]);
            if (MW'(n_start[a]) >= MW'(i_cfg.ext[a])) begin
                n_len[a] = i_cfg.size[a];
            end else if (w_diff[a] < MW'(i_cfg.size[a])) begin
                n_len[a] = CFG_W'(w_diff[a]);
            end else begin
                n_len[a] = i_cfg.size[a];
            end
        end
    end

    // horner steps, one multiply per stage
    assign n_p1 = P1W'(P1W'(i_quo[AX_TIME]) * P1W'(i_cfg.cpa[AX_DEPTH])
                  + P1W'(i_quo[AX_DEPTH]));
    assign n_p2 = P2W'(P2W'(r_p1) * P2W'(i_cfg.cpa[AX_LAT]) + P2W'(r_qlat1));
    assign n_id = ID_W'(ID_W'(r_p2) * ID_W'(i_cfg.cpa[AX_LON]) + ID_W'(r_qlon2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_start1 <= n_start;
            r_len1   <= n_len;
            r_in1    <= &w_ok;
            r_p1     <= n_p1;
            r_qlat1  <= i_quo[AX_LAT];
            r_qlon1  <= i_quo[AX_LON];
        end
        if (w_en2 && r_v1) begin
            r_start2 <= r_start1;
            r_len2   <= r_len1;
            r_in2    <= r_in1;
            r_p2     <= n_p2;
            r_qlon2  <= r_qlon1;
        end
        if (w_en3 && r_v2) begin
            r_start3 <= r_start2;
            r_len3   <= r_len2;
            r_in3    <= r_in2;
            r_id     <= n_id;
        end
    end

    assign o_valid    = r_v3;
    assign o_in_range = r_in3;
    assign o_chunk_id = r_id;
    assign o_start    = r_start3;
    assign o_len      = r_len3;

endmodule
